/* hw/rtl/i2p_pkg.sv */
// Package for the infix to postfix converter: character constants, operator codes,
// priority and character tables, decode, stack control and state types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

   // ASCII characters that steer the conversion
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NUL    = 8'h00;

   typedef logic [2:0] op_code_type;

   localparam op_code_type CODE_ADD    = 3'd0;
   localparam op_code_type CODE_SUB    = 3'd1;
   localparam op_code_type CODE_MUL    = 3'd2;
   localparam op_code_type CODE_DIV    = 3'd3;
   localparam op_code_type CODE_POW    = 3'd4;
   localparam op_code_type CODE_LPAREN = 3'd5;

   typedef logic [1:0] prio_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_OPERAND,
      KIND_OPERATOR,
      KIND_LPAREN,
      KIND_RPAREN,
      KIND_END
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      op_code_type code;
   } decode_type;

   typedef struct packed {
      logic        push;
      logic        pop;
      op_code_type code;
   } stack_cmd_type;

   typedef struct packed {
      logic        empty;
      logic        full;
      op_code_type top;
   } stack_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_OP,
      ST_POP_PAREN,
      ST_FLUSH
   } state_type;

   function automatic prio_type code_prio(input op_code_type code);
      prio_type p;
      unique case (code)
         CODE_ADD, CODE_SUB: p = 2'd1;
         CODE_MUL, CODE_DIV: p = 2'd2;
         CODE_POW:           p = 2'd3;
         default:            p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] code_char(input op_code_type code);
      logic [7:0] c;
      unique case (code)
         CODE_ADD:    c = CH_PLUS;
         CODE_SUB:    c = CH_MINUS;
         CODE_MUL:    c = CH_STAR;
         CODE_DIV:    c = CH_SLASH;
         CODE_POW:    c = CH_CARET;
         CODE_LPAREN: c = CH_LPAREN;
         default:     c = CH_NUL;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2p_req_if.sv */
// Input channel of the infix to postfix converter: valid/ready and one character.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface i2p_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_expr;

   modport source (output valid, output in_char, output end_of_expr, input ready);
   modport sink (input valid, input in_char, input end_of_expr, output ready);
endinterface

`default_nettype wire

/* hw/rtl/i2p_rsp_if.sv */
// Result channel of the infix to postfix converter: valid/ready and one postfix character.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface i2p_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;
   logic       overflow;

   modport source (output valid, output out_char, output out_last, output overflow,
                   input ready);
   modport sink (input valid, input out_char, input out_last, input overflow,
                 output ready);
endinterface

`default_nettype wire

/* hw/rtl/i2p_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/i2p_decode.sv */
// Character classifier: sorts an input character into operand, operator,
// parenthesis, end or ignored. Depends on i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_decode (
   input  wire logic [7:0]  in_char,
   input  wire logic        end_of_expr,
   output i2p_pkg::decode_type dec
);
   import i2p_pkg::*;

   logic is_digit;
   logic is_upper;
   logic is_lower;

   assign is_digit = (in_char >= 8'h30) && (in_char <= 8'h39);
   assign is_upper = (in_char >= 8'h41) && (in_char <= 8'h5A);
   assign is_lower = (in_char >= 8'h61) && (in_char <= 8'h7A);

   always_comb begin
      dec.kind = KIND_NONE;
      dec.code = CODE_ADD;
      priority if (end_of_expr) begin
         dec.kind = KIND_END;
      end else if (is_digit || is_upper || is_lower) begin
         dec.kind = KIND_OPERAND;
      end else if (in_char == CH_PLUS) begin
         dec.kind = KIND_OPERATOR;
         dec.code = CODE_ADD;
      end else if (in_char == CH_MINUS) begin
         dec.kind = KIND_OPERATOR;
         dec.code = CODE_SUB;
      end else if (in_char == CH_STAR) begin
         dec.kind = KIND_OPERATOR;
         dec.code = CODE_MUL;
      end else if (in_char == CH_SLASH) begin
         dec.kind = KIND_OPERATOR;
         dec.code = CODE_DIV;
      end else if (in_char == CH_CARET) begin
         dec.kind = KIND_OPERATOR;
         dec.code = CODE_POW;
      end else if (in_char == CH_LPAREN) begin
         dec.kind = KIND_LPAREN;
         dec.code = CODE_LPAREN;
      end else if (in_char == CH_RPAREN) begin
         dec.kind = KIND_RPAREN;
      end else if (in_char == CH_SPACE) begin
         dec.kind = KIND_NONE;
      end else begin
         dec.kind = KIND_NONE;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/i2p_stack.sv */
// Operator stack: entries in a RAM, count and cached top in registers; the top
// after a pop comes straight from the RAM read port. Depends on i2p_pkg, i2p_ram.
`timescale 1ns / 1ps
`default_nettype none

module i2p_stack #(
   parameter int DEPTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire i2p_pkg::stack_cmd_type cmd,
   output      i2p_pkg::stack_stat_type stat
);
   import i2p_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   op_code_type   top_ff, top_in;
   logic          top_sel_ff, top_sel_in;
   logic [CW-1:0] below_idx;
   op_code_type   rd_data;
   logic          wr_en;
   logic          full;
   logic          empty;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign below_idx = count_ff - CW'(2);
   assign wr_en     = cmd.push && !full;

   i2p_ram #(
      .WIDTH ($bits(op_code_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (cmd.code),
      .rd_en   (cmd.pop),
      .rd_addr (below_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in   = count_ff;
      top_in     = top_ff;
      top_sel_in = top_sel_ff;
      if (wr_en) begin
         count_in   = count_ff + CW'(1);
         top_in     = cmd.code;
         top_sel_in = 1'b0;
      end else if (cmd.pop && !empty) begin
         // the entry below arrives on the read port next cycle
         count_in   = count_ff - CW'(1);
         top_sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         top_sel_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         top_sel_ff <= top_sel_in;
      end
      top_ff <= top_in;
   end

   assign stat.empty = empty;
   assign stat.full  = full;
   assign stat.top   = top_sel_ff ? rd_data : top_ff;

endmodule

`default_nettype wire

/* hw/rtl/infix_to_postfix_converter.sv */
// Infix to postfix converter (shunting yard), top level.
// Depends on i2p_pkg, i2p_req_if, i2p_rsp_if, i2p_decode, i2p_stack.
//
// Usage: one ASCII character per transfer on req_ch; end_of_expr closes the
// expression. Postfix characters leave on rsp_ch; the expression ends with a
// zero character marked out_last. overflow is sticky and reports a push that
// was dropped on a full stack; only reset clears it.
// Sequence: an operand is accepted and its result is offered in the next
// cycle. '(' is pushed as it is accepted. An operator, ')' or end is accepted,
// then each popped operator is emitted in turn, and finally the operator is
// pushed, the '(' discarded or the terminator emitted. Pops are paced by the
// single RAM read port that supplies the next top of stack. A new character
// is taken only when the previous one has finished and the output register is
// free or being drained, so a stalled receiver holds the converter.
// Reset: synchronous; empties the stack and the output register and clears
// overflow. The stack RAM needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   i2p_req_if.sink  req_ch,
   i2p_rsp_if.source rsp_ch
);
   import i2p_pkg::*;

   state_type      state_ff, state_in;
   op_code_type    op_ff, op_in;
   logic           overflow_ff, overflow_in;
   logic           out_valid_ff;
   logic [7:0]     out_char_ff;
   logic           out_last_ff;
   logic           out_ovf_ff;

   decode_type     dec;
   stack_cmd_type  cmd;
   stack_stat_type stat;

   logic           out_free;
   logic           accept;
   logic           load;
   logic [7:0]     load_char;
   logic           load_last;
   logic           op_pops;
   logic           paren_pops;

   i2p_decode u_decode (
      .in_char     (req_ch.in_char),
      .end_of_expr (req_ch.end_of_expr),
      .dec         (dec)
   );

   i2p_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign out_free   = !out_valid_ff || rsp_ch.ready;
   assign accept     = req_ch.valid && req_ch.ready;
   assign op_pops    = !stat.empty && (code_prio(op_ff) <= code_prio(stat.top));
   assign paren_pops = !stat.empty && (stat.top != CODE_LPAREN);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (dec.kind)
                  KIND_OPERATOR: state_in = ST_POP_OP;
                  KIND_RPAREN:   state_in = ST_POP_PAREN;
                  KIND_END:      state_in = ST_FLUSH;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_POP_OP: begin
            if (!op_pops) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_PAREN: begin
            if (!paren_pops) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (stat.empty && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and stack commands
   always_comb begin
      req_ch.ready = 1'b0;
      cmd.push     = 1'b0;
      cmd.pop      = 1'b0;
      cmd.code     = op_ff;
      op_in        = op_ff;
      overflow_in  = overflow_ff;
      load         = 1'b0;
      load_char    = code_char(stat.top);
      load_last    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = out_free;
            if (accept) begin
               unique case (dec.kind)
                  KIND_OPERAND: begin
                     load      = 1'b1;
                     load_char = req_ch.in_char;
                  end
                  KIND_LPAREN: begin
                     cmd.push    = 1'b1;
                     cmd.code    = CODE_LPAREN;
                     overflow_in = overflow_ff || stat.full;
                  end
                  KIND_OPERATOR: begin
                     op_in = dec.code;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP_OP: begin
            if (op_pops) begin
               if (out_free) begin
                  load    = 1'b1;
                  cmd.pop = 1'b1;
               end
            end else begin
               cmd.push    = 1'b1;
               overflow_in = overflow_ff || stat.full;
            end
         end
         ST_POP_PAREN: begin
            if (paren_pops) begin
               if (out_free) begin
                  load    = 1'b1;
                  cmd.pop = 1'b1;
               end
            end else if (!stat.empty) begin
               // drop the matching '('
               cmd.pop = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               load = 1'b1;
               if (stat.empty) begin
                  load_char = CH_NUL;
                  load_last = 1'b1;
               end else begin
                  cmd.pop = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      op_ff <= op_in;
      if (load) begin
         out_char_ff <= load_char;
         out_last_ff <= load_last;
         out_ovf_ff  <= overflow_ff;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_char = out_char_ff;
   assign rsp_ch.out_last = out_last_ff;
   assign rsp_ch.overflow = out_ovf_ff;

   // overflow never clears outside reset
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared without reset");

   // the stack never pushes and pops in the same cycle
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("stack push and pop together");

   // the terminator is produced only once the stack is drained
   a_term_empty: assert property (@(posedge clock) disable iff (reset)
      (load && load_last) |-> (stat.empty && load_char == CH_NUL))
      else $error("terminator with a non-empty stack");

   // a transfer in is taken only with a free output register
   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == ST_IDLE && out_free))
      else $error("character taken while busy");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for infix_to_postfix_converter: directed table, then random expressions.
// Depends on i2p_pkg, i2p_req_if, i2p_rsp_if and the converter RTL.
`timescale 1ns / 1ps

module testbench;
   import i2p_pkg::*;

   localparam int STACK_DEPTH   = 32;
   localparam int RANDOM_ITEMS  = 320;
   localparam int MAX_IDLE      = 17;
   localparam int DRAIN_CYCLES  = 80;
   localparam int N_DIRECTED    = 25;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       ovf;
   } postfix_sym_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoe;
   } infix_item_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoe;
      logic       typed;
      logic       has_sym;
      logic [7:0] sym;
      logic       last;
   } directed_row_type;

   // typed rows carry their own expectation; the rest are checked against the converter model
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      '{CH_NUL,    1'b1, 1'b1, 1'b1, CH_NUL, 1'b1},   // end on an empty stack
      '{8'h41,     1'b0, 1'b1, 1'b1, 8'h41,  1'b0},
      '{8'h7A,     1'b0, 1'b1, 1'b1, 8'h7A,  1'b0},
      '{8'h30,     1'b0, 1'b1, 1'b1, 8'h30,  1'b0},
      '{8'h39,     1'b0, 1'b1, 1'b1, 8'h39,  1'b0},
      '{8'hFF,     1'b0, 1'b1, 1'b0, CH_NUL, 1'b0},   // non-ASCII byte, dropped
      '{8'h80,     1'b0, 1'b1, 1'b0, CH_NUL, 1'b0},
      '{CH_SPACE,  1'b0, 1'b1, 1'b0, CH_NUL, 1'b0},
      '{CH_LPAREN, 1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{8'h61,     1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{CH_PLUS,   1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{8'h62,     1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{CH_STAR,   1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{8'h63,     1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{CH_CARET,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{8'h64,     1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{CH_CARET,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},   // equal priority pops the first caret
      '{8'h65,     1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{CH_RPAREN, 1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{CH_MINUS,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{8'h66,     1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{CH_SLASH,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
      '{CH_RPAREN, 1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},   // no matching bracket: empties the stack
      '{CH_LPAREN, 1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},   // left open at the end
      '{8'hFF,     1'b1, 1'b0, 1'b0, CH_NUL, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2p_req_if req_ch ();
   i2p_rsp_if rsp_ch ();

   infix_to_postfix_converter #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #10 clock = ~clock;

   // converter model state
   op_code_type     op_stack [STACK_DEPTH];
   int              stack_fill;
   logic            ovf_sticky;
   postfix_sym_type step_syms [$];
   postfix_sym_type pending_syms [$];

   infix_item_type  char_feed [$];
   int              err_count;
   int              effective_sent;
   bit              tx_quiet;
   bit              rx_quiet;

   function automatic logic [1:0] op_prio(input op_code_type code);
      case (code)
         CODE_ADD, CODE_SUB: return 2'd1;
         CODE_MUL, CODE_DIV: return 2'd2;
         CODE_POW:           return 2'd3;
         default:            return 2'd0;
      endcase
   endfunction

   function automatic logic [7:0] op_glyph(input op_code_type code);
      case (code)
         CODE_ADD:    return CH_PLUS;
         CODE_SUB:    return CH_MINUS;
         CODE_MUL:    return CH_STAR;
         CODE_DIV:    return CH_SLASH;
         CODE_POW:    return CH_CARET;
         CODE_LPAREN: return CH_LPAREN;
         default:     return CH_NUL;
      endcase
   endfunction

   function automatic bit decode_op(input logic [7:0] ch, output op_code_type code);
      code = CODE_ADD;
      case (ch)
         CH_PLUS:  code = CODE_ADD;
         CH_MINUS: code = CODE_SUB;
         CH_STAR:  code = CODE_MUL;
         CH_SLASH: code = CODE_DIV;
         CH_CARET: code = CODE_POW;
         default:  return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic bit is_operand(input logic [7:0] ch);
      return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
             (ch >= 8'h61 && ch <= 8'h7A);
   endfunction

   function automatic bit is_effective(input logic [7:0] ch, input logic eoe);
      op_code_type code;
      return eoe || is_operand(ch) || decode_op(ch, code) ||
             ch == CH_LPAREN || ch == CH_RPAREN;
   endfunction

   task automatic emit_sym(input logic [7:0] ch, input logic last);
      postfix_sym_type s;
      s.ch   = ch;
      s.last = last;
      s.ovf  = 1'b0;
      step_syms.push_back(s);
   endtask

   task automatic push_op(input op_code_type code);
      if (stack_fill >= STACK_DEPTH) begin
         ovf_sticky = 1'b1;
      end else begin
         op_stack[stack_fill] = code;
         stack_fill++;
      end
   endtask

   task automatic convert_step(input logic [7:0] ch, input logic eoe);
      op_code_type code;
      step_syms.delete();
      if (eoe) begin
         while (stack_fill > 0) begin
            emit_sym(op_glyph(op_stack[stack_fill-1]), 1'b0);
            stack_fill--;
         end
         emit_sym(CH_NUL, 1'b1);
      end else if (is_operand(ch)) begin
         emit_sym(ch, 1'b0);
      end else if (decode_op(ch, code)) begin
         while (stack_fill > 0 && op_prio(code) <= op_prio(op_stack[stack_fill-1])) begin
            emit_sym(op_glyph(op_stack[stack_fill-1]), 1'b0);
            stack_fill--;
         end
         push_op(code);
      end else if (ch == CH_LPAREN) begin
         push_op(CODE_LPAREN);
      end else if (ch == CH_RPAREN) begin
         while (stack_fill > 0 && op_stack[stack_fill-1] != CODE_LPAREN) begin
            emit_sym(op_glyph(op_stack[stack_fill-1]), 1'b0);
            stack_fill--;
         end
         if (stack_fill > 0) stack_fill--;
      end
      // flag as it stands after the whole step
      foreach (step_syms[i]) step_syms[i].ovf = ovf_sticky;
   endtask

   task automatic offer_char(input logic [7:0] ch, input logic eoe);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.in_char     <= ch;
      req_ch.end_of_expr <= eoe;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic feed_char(input logic [7:0] ch, input logic eoe);
      infix_item_type it;
      it.ch  = ch;
      it.eoe = eoe;
      char_feed.push_back(it);
   endtask

   task automatic feed_operand();
      case ($urandom_range(0, 2))
         0:       feed_char(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
         1:       feed_char(8'h41 + 8'($urandom_range(0, 25)), 1'b0);
         default: feed_char(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
      endcase
   endtask

   task automatic feed_operator();
      case ($urandom_range(0, 4))
         0:       feed_char(CH_PLUS, 1'b0);
         1:       feed_char(CH_MINUS, 1'b0);
         2:       feed_char(CH_STAR, 1'b0);
         3:       feed_char(CH_SLASH, 1'b0);
         default: feed_char(CH_CARET, 1'b0);
      endcase
   endtask

   // broken: leave brackets open or throw in a stray closing one
   task automatic build_expr(input bit broken);
      int depth;
      int terms;
      depth = 0;
      terms = $urandom_range(1, 8);
      for (int t = 0; t < terms; t++) begin
         while ($urandom_range(0, 3) == 0 && depth < 12) begin
            feed_char(CH_LPAREN, 1'b0);
            depth++;
         end
         feed_operand();
         if ($urandom_range(0, 7) == 0) feed_char(CH_SPACE, 1'b0);
         if (broken && $urandom_range(0, 5) == 0) feed_char(CH_RPAREN, 1'b0);
         while (depth > 0 && $urandom_range(0, 2) == 0) begin
            feed_char(CH_RPAREN, 1'b0);
            depth--;
         end
         if (t < terms - 1) feed_operator();
      end
      if (!broken || $urandom_range(0, 1) == 0) begin
         while (depth > 0) begin
            feed_char(CH_RPAREN, 1'b0);
            depth--;
         end
      end
      feed_char(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic build_noise();
      int len;
      len = $urandom_range(1, 10);
      repeat (len) feed_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
   endtask

   // nest deeper than the stack so the push is dropped
   task automatic build_deep_expr();
      int levels;
      levels = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 8);
      repeat (levels) begin
         feed_char(CH_LPAREN, 1'b0);
         if ($urandom_range(0, 1) == 0) begin
            feed_operand();
            feed_operator();
         end
      end
      feed_operand();
      repeat ($urandom_range(0, 4)) feed_char(CH_RPAREN, 1'b0);
      feed_char(CH_NUL, 1'b1);
   endtask

   task automatic run_feed();
      infix_item_type it;
      tx_quiet = ($urandom_range(0, 3) == 0);
      while (char_feed.size() != 0) begin
         it = char_feed.pop_front();
         offer_char(it.ch, it.eoe);
         convert_step(it.ch, it.eoe);
         foreach (step_syms[i]) pending_syms.push_back(step_syms[i]);
         if (is_effective(it.ch, it.eoe)) effective_sent++;
      end
   endtask

   // result side: random stalls, compare each transfer with the oldest expectation
   initial begin
      int stall;
      int since_flip;
      postfix_sym_type want;
      rsp_ch.ready = 1'b0;
      rx_quiet     = 1'b0;
      since_flip   = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (++since_flip > 30) begin
            since_flip = 0;
            rx_quiet   = ($urandom_range(0, 3) == 0);
         end
         stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         if (pending_syms.size() == 0) begin
            $error("unexpected result out_char %h out_last %b", rsp_ch.out_char,
                   rsp_ch.out_last);
            err_count++;
         end else begin
            want = pending_syms.pop_front();
            if (rsp_ch.out_char !== want.ch) begin
               $error("out_char expected %h actual %h", want.ch, rsp_ch.out_char);
               err_count++;
            end
            if (rsp_ch.out_last !== want.last) begin
               $error("out_last expected %b actual %b", want.last, rsp_ch.out_last);
               err_count++;
            end
            if (rsp_ch.overflow !== want.ovf) begin
               $error("overflow expected %b actual %b", want.ovf, rsp_ch.overflow);
               err_count++;
            end
         end
      end
   end

   initial begin
      postfix_sym_type s;
      int deep_done;
      int pick;
      req_ch.valid       = 1'b0;
      req_ch.in_char     = CH_NUL;
      req_ch.end_of_expr = 1'b0;
      stack_fill     = 0;
      ovf_sticky     = 1'b0;
      err_count      = 0;
      effective_sent = 0;
      deep_done      = 0;
      tx_quiet       = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         offer_char(DIRECTED[r].ch, DIRECTED[r].eoe);
         convert_step(DIRECTED[r].ch, DIRECTED[r].eoe);
         if (DIRECTED[r].typed) begin
            if (DIRECTED[r].has_sym) begin
               s.ch   = DIRECTED[r].sym;
               s.last = DIRECTED[r].last;
               s.ovf  = 1'b0;
               pending_syms.push_back(s);
            end
         end else begin
            foreach (step_syms[i]) pending_syms.push_back(step_syms[i]);
         end
      end

      effective_sent = 0;
      while (effective_sent < RANDOM_ITEMS) begin
         if (effective_sent >= RANDOM_ITEMS - 60 && deep_done < 2) begin
            build_deep_expr();
            deep_done++;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) build_expr(1'b0);
            else if (pick == 7) build_expr(1'b1);
            else build_noise();
         end
         run_feed();
      end
      req_ch.valid <= 1'b0;

      while (pending_syms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_syms.size() != 0) begin
         $error("results still outstanding: %0d", pending_syms.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("infix_to_postfix_converter verification clean");
      end else begin
         $display("infix_to_postfix_converter verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("infix_to_postfix_converter verification failed");
      $finish;
   end

endmodule
